/* rtl/core/uprt_pkg.sv */
// Shared types and constants for the uid/pid register table.
// No dependencies; imported by the sequencer, the core and the testbench.
`default_nettype none

package uprt_pkg;

   localparam int USER_W      = 32;
   localparam int PID_W       = 31;
   localparam int DEF_ENTRIES = 16;

   // Stream beat widths; the tdata widths are padded to whole bytes.
   localparam int REQ_DATA_W = ((USER_W + PID_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((PID_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   // One result beat.
   typedef struct packed {
      logic             ok;
      logic             reused;
      logic [PID_W-1:0] pid_value;
   } uprt_res_type;

   // Write enables for the two table memories.
   typedef struct packed {
      logic user_we;
      logic proc_we;
   } uprt_wr_type;

endpackage : uprt_pkg

`default_nettype wire

/* rtl/core/uprt_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`default_nettype none

module uprt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : uprt_ram

`default_nettype wire

/* rtl/core/uprt_ctrl.sv */
// Scan sequencer: walks the used part of the table, matches the uid,
// and updates or claims an entry. Depends on uprt_pkg.
`default_nettype none

module uprt_ctrl #(
   parameter int ENTRIES = 16,
   parameter int IDXW    = 4,
   parameter int CNTW    = 5
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // item in
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [uprt_pkg::USER_W-1:0]  in_user,
   input  wire logic [uprt_pkg::PID_W-1:0]   in_pid,
   // result out
   output logic                              res_valid,
   output uprt_pkg::uprt_res_type            res,
   input  wire logic                         res_ready,
   // table memories
   output uprt_pkg::uprt_wr_type             wr_ctl,
   output logic      [IDXW-1:0]              wr_addr,
   output logic      [uprt_pkg::USER_W-1:0]  wr_user,
   output logic      [uprt_pkg::PID_W-1:0]   wr_pid,
   output logic                              rd_en,
   output logic      [IDXW-1:0]              rd_addr,
   input  wire logic [uprt_pkg::USER_W-1:0]  rd_user,
   input  wire logic [uprt_pkg::PID_W-1:0]   rd_pid
);

   import uprt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(ENTRIES);

   logic [1:0]        state_ff, state_in;
   // Entries are only ever claimed lowest-first and never freed, so the
   // used entries are exactly [0, count).
   logic [CNTW-1:0]   count_ff, count_in;
   logic [CNTW-1:0]   issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDXW-1:0]   chk_idx_ff, chk_idx_in;
   logic [USER_W-1:0] user_ff, user_in;
   logic [PID_W-1:0]  pid_ff, pid_in;
   uprt_res_type      res_ff, res_in;

   logic hit;
   logic scan_end;

   assign in_ready  = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   assign hit      = chk_vld_ff && (rd_user == user_ff);
   assign scan_end = !chk_vld_ff && (issue_ff == count_ff);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      issue_in   = issue_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = chk_idx_ff;
      user_in    = user_ff;
      pid_in     = pid_ff;
      res_in     = res_ff;
      wr_ctl     = '0;
      wr_addr    = chk_idx_ff;
      wr_user    = user_ff;
      wr_pid     = pid_ff;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[IDXW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               user_in  = in_user;
               pid_in   = in_pid;
               issue_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // update in place, answer with the old pid
               wr_ctl.proc_we   = 1'b1;
               wr_addr          = chk_idx_ff;
               res_in.ok        = 1'b1;
               res_in.reused    = 1'b1;
               res_in.pid_value = rd_pid;
               state_in         = ST_DONE;
            end else if (scan_end) begin
               if (count_ff != FULL_CNT) begin
                  // claim the first unused entry
                  wr_ctl.user_we   = 1'b1;
                  wr_ctl.proc_we   = 1'b1;
                  wr_addr          = count_ff[IDXW-1:0];
                  count_in         = count_ff + CNTW'(1);
                  res_in.ok        = 1'b1;
                  res_in.reused    = 1'b0;
                  res_in.pid_value = pid_ff;
               end else begin
                  res_in = '0;
               end
               state_in = ST_DONE;
            end else if (issue_ff != count_ff) begin
               rd_en      = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDXW-1:0];
               issue_in   = issue_ff + CNTW'(1);
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      user_ff    <= user_in;
      pid_ff     <= pid_in;
      res_ff     <= res_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("fill count beyond table size");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNTW'(1) && $past(state_ff) == ST_SCAN))
      else $error("fill count moved by other than one claim");

   a_read_in_use: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (issue_ff < count_ff))
      else $error("read issued past the used entries");

   a_write_once: assert property (@(posedge clock) disable iff (reset)
      (wr_ctl.proc_we || wr_ctl.user_we) |=> (state_ff == ST_DONE))
      else $error("table write outside the end of a scan");

endmodule : uprt_ctrl

`default_nettype wire

/* rtl/core/uid_pid_register_table_core.sv */
// One request at a time: a new beat is accepted only after the previous result
// has moved to the output register. A miss scans every entry in use; a hit on
// entry k stops the scan there. The scan reads one entry per cycle through the
// single read port of each table memory, so the fill level sets the rate.
// Reset: synchronous, active high; marks every entry unused (fill count to 0),
// no clearing pass. Memory contents are left as they are.
`default_nettype none

module uid_pid_register_table_core #(
   parameter int ENTRIES = uprt_pkg::DEF_ENTRIES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] user_id, [62:32] process_id, [63] zero
   input  wire logic [uprt_pkg::REQ_DATA_W-1:0] req_tdata,
   // response stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [30:0] pid_value, [31] zero
   output logic      [uprt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] ok, [1] reused
   output logic      [uprt_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import uprt_pkg::*;

   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNTW = $clog2(ENTRIES + 1);

   uprt_res_type      res;
   logic              res_valid;
   logic              res_ready;
   uprt_wr_type       wr_ctl;
   logic [IDXW-1:0]   wr_addr;
   logic [USER_W-1:0] wr_user;
   logic [PID_W-1:0]  wr_pid;
   logic              rd_en;
   logic [IDXW-1:0]   rd_addr;
   logic [USER_W-1:0] rd_user;
   logic [PID_W-1:0]  rd_pid;

   // Output register: a finished result parks here so the sequencer can
   // take the next beat while the consumer stalls.
   logic              rsp_valid_ff, rsp_valid_in;
   uprt_res_type      rsp_res_ff, rsp_res_in;

   uprt_ctrl #(
      .ENTRIES (ENTRIES),
      .IDXW    (IDXW),
      .CNTW    (CNTW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_user   (req_tdata[USER_W-1:0]),
      .in_pid    (req_tdata[USER_W+PID_W-1:USER_W]),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_user   (wr_user),
      .wr_pid    (wr_pid),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_user   (rd_user),
      .rd_pid    (rd_pid)
   );

   // uid and pid sit in separate memories so an update rewrites the pid only
   uprt_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (USER_W),
      .AW    (IDXW)
   ) u_user_mem (
      .clock   (clock),
      .wr_en   (wr_ctl.user_we),
      .wr_addr (wr_addr),
      .wr_data (wr_user),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_user)
   );

   uprt_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (PID_W),
      .AW    (IDXW)
   ) u_proc_mem (
      .clock   (clock),
      .wr_en   (wr_ctl.proc_we),
      .wr_addr (wr_addr),
      .wr_data (wr_pid),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_pid)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - PID_W){1'b0}}, rsp_res_ff.pid_value};
   assign rsp_tuser  = {rsp_res_ff.reused, rsp_res_ff.ok};

   a_reused_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_res_ff.reused || rsp_res_ff.ok))
      else $error("reused result without ok");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_res_ff.ok) |-> (rsp_res_ff.pid_value == '0))
      else $error("failed result carries a pid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_res_ff)))
      else $error("pending result lost");

endmodule : uid_pid_register_table_core

`default_nettype wire

/* sim/uid_pid_register_table_core_tb.sv */
// Self-checking testbench for uid_pid_register_table_core: random and directed
// registrations against an in-bench lookup-or-insert table. Depends on uprt_pkg and the core.
`default_nettype none

// Mirror of the uid -> pid table; predicts one reply per accepted request beat.
class pid_table_model;
   localparam int DEPTH = uprt_pkg::DEF_ENTRIES;

   bit                            slot_used [DEPTH];
   bit [uprt_pkg::USER_W-1:0]     slot_user [DEPTH];
   bit [uprt_pkg::PID_W-1:0]      slot_pid  [DEPTH];
   uprt_pkg::uprt_res_type        pending_replies [$];
   int                            error_count;

   // Index of the live entry holding uid, or -1.
   function int find_user(bit [uprt_pkg::USER_W-1:0] uid);
      for (int i = 0; i < DEPTH; i++) begin
         if (slot_used[i] && slot_user[i] == uid) return i;
      end
      return -1;
   endfunction

   function void register_user(bit [uprt_pkg::USER_W-1:0] uid, bit [uprt_pkg::PID_W-1:0] pid);
      uprt_pkg::uprt_res_type reply;
      int hit;
      int free_slot;
      hit       = find_user(uid);
      free_slot = -1;
      reply     = '0;
      if (hit >= 0) begin
         reply.ok        = 1'b1;
         reply.reused    = 1'b1;
         reply.pid_value = slot_pid[hit];
         slot_pid[hit]   = pid;
      end else begin
         for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
         end
         if (free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_user[free_slot] = uid;
            slot_pid[free_slot]  = pid;
            reply.ok             = 1'b1;
            reply.pid_value      = pid;
         end
      end
      pending_replies.push_back(reply);
   endfunction

   function void check_reply(uprt_pkg::uprt_res_type got);
      uprt_pkg::uprt_res_type want;
      if (pending_replies.size() == 0) begin
         $error("unexpected reply beat: ok %0d reused %0d pid_value 0x%08h",
                got.ok, got.reused, got.pid_value);
         error_count++;
         return;
      end
      want = pending_replies.pop_front();
      if (got.ok !== want.ok) begin
         $error("field ok: expected %0d, got %0d", want.ok, got.ok);
         error_count++;
      end
      if (got.reused !== want.reused) begin
         $error("field reused: expected %0d, got %0d", want.reused, got.reused);
         error_count++;
      end
      if (got.pid_value !== want.pid_value) begin
         $error("field pid_value: expected 0x%08h, got 0x%08h",
                want.pid_value, got.pid_value);
         error_count++;
      end
   endfunction
endclass

module uid_pid_register_table_core_tb;
   import uprt_pkg::*;

   localparam int TABLE_DEPTH    = DEF_ENTRIES;
   localparam int RANDOM_ITEMS   = 1030;
   localparam int MAX_SEND_GAP   = 20;
   localparam int MAX_STALL      = 15;
   // Worst case between two accepted beats: full scan plus the longest sender
   // gap plus the longest receiver stall; taken many times over.
   localparam int WATCHDOG_LIMIT = 20 * (TABLE_DEPTH + 4 + MAX_SEND_GAP + MAX_STALL);
   localparam int DRAIN_CYCLES   = 2 * (TABLE_DEPTH + 4) + 8;
   localparam logic [PID_W-1:0] PID_MAX  = '1;
   localparam logic [USER_W-1:0] USER_MAX = '1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [31:0] user_id, [62:32] process_id, [63] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [30:0] pid_value, [31] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] ok, [1] reused
   logic [RSP_USER_W-1:0] rsp_tuser;

   pid_table_model tracker = new;

   // receiver pattern state
   int stall_left = 0;
   int ready_mode = 0;
   int mode_left  = 0;
   int idle_cycles = 0;

   uid_pid_register_table_core #(
      .ENTRIES (TABLE_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Holds one beat until accepted; the table mirror is updated at the same
   // edge so expectations stay in accept order.
   task automatic send_item(input logic [USER_W-1:0] uid, input logic [PID_W-1:0] pid);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, pid, uid};
      do @(posedge clock); while (!req_tready);
      tracker.register_user(uid, pid);
   endtask

   // Drops valid for a while; garbage on tdata must be ignored.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= {1'b0, PID_W'($urandom()), USER_W'($urandom())};
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Fresh uid that no live entry holds.
   function automatic logic [USER_W-1:0] unused_user();
      logic [USER_W-1:0] uid;
      do uid = $urandom(); while (tracker.find_user(uid) >= 0);
      return uid;
   endfunction

   function automatic logic [PID_W-1:0] random_pid();
      return PID_W'($urandom());
   endfunction

   task automatic run_directed();
      logic [USER_W-1:0] uid;
      // extremes of both fields on an empty table
      send_item('0, '0);
      send_item(USER_MAX, PID_MAX);
      // hit on the first entry, then the same pid again (still counts as reused)
      send_item('0, PID_MAX);
      send_item('0, PID_MAX);
      send_item(USER_MAX, '0);
      // fill the remaining entries, lowest free slot first
      while (tracker.find_user(unused_user()) < 0 && !tracker.slot_used[TABLE_DEPTH-1]) begin
         send_item(unused_user(), random_pid());
      end
      // table full: a new uid fails, a one-bit neighbor of a stored uid fails
      send_item(unused_user(), random_pid());
      uid = tracker.slot_user[TABLE_DEPTH-1] ^ 32'h0000_0001;
      if (tracker.find_user(uid) < 0) send_item(uid, PID_MAX);
      // hits on the last entry (longest scan) and the first one while full
      send_item(tracker.slot_user[TABLE_DEPTH-1], random_pid());
      send_item(tracker.slot_user[0], '0);
      send_item(unused_user(), PID_MAX);
   endtask

   task automatic run_random();
      logic [USER_W-1:0] uid;
      logic [PID_W-1:0]  pid;
      int sent;
      int burst;
      int slot;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            slot = $urandom_range(0, TABLE_DEPTH - 1);
            // mostly hits on live entries, some near misses and foreign uids
            case ($urandom_range(0, 19))
               0, 1, 2, 3:  uid = unused_user();
               4, 5:        uid = tracker.slot_user[slot] ^ (32'h1 << $urandom_range(0, 31));
               default:     uid = tracker.slot_user[slot];
            endcase
            case ($urandom_range(0, 9))
               0:       pid = '0;
               1:       pid = PID_MAX;
               2:       pid = (tracker.find_user(uid) >= 0) ?
                              tracker.slot_pid[tracker.find_user(uid)] : random_pid();
               default: pid = random_pid();
            endcase
            send_item(uid, pid);
            sent++;
         end
         // a quarter of the bursts run straight into the next one
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, MAX_SEND_GAP));
      end
      req_tvalid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Receiver cycles through phases: always ready, random drops, long stalls.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(16, 96);
      end else begin
         mode_left = mode_left - 1;
      end
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               stall_left = $urandom_range(1, MAX_STALL);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   // Reply check at every accepted result beat.
   always @(posedge clock) begin
      uprt_res_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok        = rsp_tuser[0];
         got.reused    = rsp_tuser[1];
         got.pid_value = rsp_tdata[PID_W-1:0];
         tracker.check_reply(got);
      end
   end

   // Watchdog: too long without any beat on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      // catch stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.error_count == 0 && tracker.pending_replies.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/uprt_pkg.sv
rtl/core/uprt_ram.sv
rtl/core/uprt_ctrl.sv
rtl/core/uid_pid_register_table_core.sv
sim/uid_pid_register_table_core_tb.sv
